// ===== sv/lkhc_pkg.sv =====
// Shared types and constants for the keyed handle cache.
// No dependencies; imported by lkhc_lru_list and lru_keyed_handle_cache.
`default_nettype none

package lkhc_pkg;

   localparam int KEY_VALUES_W = 64;
   localparam int KEY_MASK_W   = 23;
   localparam int KEY_W        = KEY_VALUES_W + KEY_MASK_W;
   localparam int SLOT_W       = 7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LREAD,
      ST_UNLINK,
      ST_DETACH,
      ST_APPEND
   } state_type;

   // Commands to the recency list, one per cycle.
   typedef enum logic [2:0] {
      LST_NOP,
      LST_READ,
      LST_UNLINK,
      LST_DETACH,
      LST_APPEND
   } list_op_type;

endpackage

`default_nettype wire

// ===== sv/lkhc_lru_list.sv =====
// Recency list of the cache: doubly linked older/newer link memories plus
// the oldest and newest end pointers. Depends on lkhc_pkg.
`default_nettype none

module lkhc_lru_list #(
   parameter int  ENTRIES = 128,
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int LINK_W  = IDX_W + 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lkhc_pkg::list_op_type cmd,
   input  wire logic [IDX_W-1:0]      cmd_slot,
   output logic      [LINK_W-1:0]     oldest,
   output logic      [LINK_W-1:0]     newest
);
   import lkhc_pkg::*;

   // Top bit set means no slot.
   localparam logic [LINK_W-1:0] NONE = '1;

   logic [LINK_W-1:0] older_mem [ENTRIES];
   logic [LINK_W-1:0] newer_mem [ENTRIES];

   logic [LINK_W-1:0] o_rd_ff;
   logic [LINK_W-1:0] n_rd_ff;
   logic [LINK_W-1:0] oldest_ff, oldest_in;
   logic [LINK_W-1:0] newest_ff, newest_in;

   logic              older_we, newer_we;
   logic [IDX_W-1:0]  older_wa, newer_wa;
   logic [LINK_W-1:0] older_wd, newer_wd;
   logic [LINK_W-1:0] slot_link;

   assign slot_link = {1'b0, cmd_slot};

   always_comb begin
      oldest_in = oldest_ff;
      newest_in = newest_ff;
      older_we  = 1'b0;
      newer_we  = 1'b0;
      older_wa  = cmd_slot;
      newer_wa  = cmd_slot;
      older_wd  = NONE;
      newer_wd  = NONE;
      unique case (cmd)
         LST_NOP, LST_READ: begin
         end
         LST_UNLINK: begin
            // bridge the neighbors of the slot read by LST_READ
            if (!o_rd_ff[LINK_W-1]) begin
               newer_we = 1'b1;
               newer_wa = o_rd_ff[IDX_W-1:0];
               newer_wd = n_rd_ff;
            end else begin
               oldest_in = n_rd_ff;
            end
            if (!n_rd_ff[LINK_W-1]) begin
               older_we = 1'b1;
               older_wa = n_rd_ff[IDX_W-1:0];
               older_wd = o_rd_ff;
            end else begin
               newest_in = o_rd_ff;
            end
         end
         LST_DETACH: begin
            newer_we = 1'b1;
            newer_wd = NONE;
            older_we = 1'b1;
            older_wd = newest_ff;
         end
         LST_APPEND: begin
            if (!newest_ff[LINK_W-1]) begin
               newer_we = 1'b1;
               newer_wa = newest_ff[IDX_W-1:0];
               newer_wd = slot_link;
            end
            newest_in = slot_link;
            if (oldest_ff[LINK_W-1]) begin
               oldest_in = slot_link;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= NONE;
         newest_ff <= NONE;
      end else begin
         oldest_ff <= oldest_in;
         newest_ff <= newest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (older_we) begin
         older_mem[older_wa] <= older_wd;
      end
      if (newer_we) begin
         newer_mem[newer_wa] <= newer_wd;
      end
      if (cmd == LST_READ) begin
         o_rd_ff <= older_mem[cmd_slot];
         n_rd_ff <= newer_mem[cmd_slot];
      end
   end

   assign oldest = oldest_ff;
   assign newest = newest_ff;

endmodule

`default_nettype wire

// ===== sv/lru_keyed_handle_cache.sv =====
// After start is taken, one key comparator walks the key memory one slot per cycle over the slots
// in use (at most CACHE_ENTRIES), then up to four list-update steps follow before the result strobe.
// Throughput: one item at a time, busy until the strobe; a new start is taken in the strobe cycle.
// Results cannot be stalled.
// Reset (synchronous): cache empty, recency list empty; memories are not cleared.
// Depends on lkhc_pkg and lkhc_lru_list.
`default_nettype none

module lru_keyed_handle_cache #(
   parameter int CACHE_ENTRIES = 128
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [lkhc_pkg::KEY_VALUES_W-1:0] req_key_values,
   input  wire logic [lkhc_pkg::KEY_MASK_W-1:0]   req_key_mask,
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic      [lkhc_pkg::SLOT_W-1:0]       rsp_slot,
   output logic                                   rsp_evicted
);
   import lkhc_pkg::*;

   localparam int IDX_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int LINK_W = IDX_W + 1;
   localparam logic [LINK_W-1:0] FULL_COUNT = LINK_W'(CACHE_ENTRIES);

   state_type state_ff, state_in;

   logic [KEY_W-1:0] key_mem [CACHE_ENTRIES];
   logic [KEY_W-1:0] key_rd_ff;

   logic [KEY_VALUES_W-1:0] kv_ff, kv_in;
   logic [KEY_MASK_W-1:0]   km_ff, km_in;
   logic [LINK_W-1:0]       scan_ff, scan_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]        cmp_idx_ff, cmp_idx_in;
   logic [LINK_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]        slot_ff, slot_in;
   logic                    hit_ff, hit_in;
   logic                    evict_ff, evict_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic                    rsp_evicted_ff, rsp_evicted_in;

   logic                    accept;
   logic                    match;
   logic                    miss;
   logic                    full;
   logic                    is_newest;
   logic                    key_rd_en;
   logic                    key_wr_en;
   logic [IDX_W-1:0]        key_wr_addr;
   logic [IDX_W-1:0]        rsp_src;
   logic [IDX_W+SLOT_W-1:0] slot_ext;
   list_op_type             lst_cmd;
   logic [LINK_W-1:0]       oldest;
   logic [LINK_W-1:0]       newest;

   lkhc_lru_list #(
      .ENTRIES (CACHE_ENTRIES)
   ) u_list (
      .clock    (clock),
      .reset    (reset),
      .cmd      (lst_cmd),
      .cmd_slot (slot_ff),
      .oldest   (oldest),
      .newest   (newest)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign match     = cmp_vld_ff && (key_rd_ff == {kv_ff, km_ff});
   // last compare lands in the cycle the scan pointer reaches the fill count
   assign miss      = !match && (scan_ff == fill_ff);
   assign full      = (fill_ff == FULL_COUNT);
   assign is_newest = (newest == {1'b0, cmp_idx_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (match) begin
               state_in = is_newest ? ST_IDLE : ST_LREAD;
            end else if (miss) begin
               state_in = full ? ST_LREAD : ST_DETACH;
            end
         end
         ST_LREAD:  state_in = ST_UNLINK;
         ST_UNLINK: state_in = ST_DETACH;
         ST_DETACH: state_in = ST_APPEND;
         ST_APPEND: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      key_rd_en      = 1'b0;
      key_wr_en      = 1'b0;
      key_wr_addr    = full ? oldest[IDX_W-1:0] : fill_ff[IDX_W-1:0];
      lst_cmd        = LST_NOP;
      rsp_valid_in   = 1'b0;
      rsp_hit_in     = hit_ff;
      rsp_evicted_in = evict_ff;
      rsp_src        = slot_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_SCAN: begin
            key_rd_en = (scan_ff < fill_ff);
            key_wr_en = miss;
            if (match && is_newest) begin
               rsp_valid_in   = 1'b1;
               rsp_hit_in     = 1'b1;
               rsp_evicted_in = 1'b0;
               rsp_src        = cmp_idx_ff;
            end
         end
         ST_LREAD:  lst_cmd = LST_READ;
         ST_UNLINK: lst_cmd = LST_UNLINK;
         ST_DETACH: lst_cmd = LST_DETACH;
         ST_APPEND: begin
            lst_cmd      = LST_APPEND;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
      slot_ext    = {{SLOT_W{1'b0}}, rsp_src};
      rsp_slot_in = slot_ext[SLOT_W-1:0];
   end

   // datapath
   always_comb begin
      kv_in      = kv_ff;
      km_in      = km_ff;
      scan_in    = scan_ff;
      cmp_vld_in = cmp_vld_ff;
      cmp_idx_in = cmp_idx_ff;
      fill_in    = fill_ff;
      slot_in    = slot_ff;
      hit_in     = hit_ff;
      evict_in   = evict_ff;
      if (accept) begin
         kv_in      = req_key_values;
         km_in      = req_key_mask;
         scan_in    = '0;
         cmp_vld_in = 1'b0;
      end
      if (state_ff == ST_SCAN) begin
         if (key_rd_en) begin
            cmp_idx_in = scan_ff[IDX_W-1:0];
            cmp_vld_in = 1'b1;
            scan_in    = scan_ff + LINK_W'(1);
         end else begin
            cmp_vld_in = 1'b0;
         end
         if (match) begin
            slot_in  = cmp_idx_ff;
            hit_in   = 1'b1;
            evict_in = 1'b0;
         end else if (miss) begin
            slot_in  = key_wr_addr;
            hit_in   = 1'b0;
            evict_in = full;
            if (!full) begin
               fill_in = fill_ff + LINK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kv_ff          <= kv_in;
      km_ff          <= km_in;
      scan_ff        <= scan_in;
      cmp_idx_ff     <= cmp_idx_in;
      slot_ff        <= slot_in;
      hit_ff         <= hit_in;
      evict_ff       <= evict_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_evicted_ff <= rsp_evicted_in;
   end

   // key memory: one read port for the scan, one write port for fills
   always_ff @(posedge clock) begin
      if (key_wr_en) begin
         key_mem[key_wr_addr] <= {kv_ff, km_ff};
      end
      if (key_rd_en) begin
         key_rd_ff <= key_mem[scan_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_slot    = rsp_slot_ff;
   assign rsp_evicted = rsp_evicted_ff;

`ifndef SYNTHESIS
   a_evict_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_evicted_ff |-> fill_ff == FULL_COUNT)
      else $error("eviction reported while a slot was free");

   a_rsp_frees_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe while still busy");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> scan_ff <= fill_ff)
      else $error("scan ran past filled slots");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_COUNT)
      else $error("fill count beyond cache size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");
`endif

endmodule

`default_nettype wire
